// File: hdl/rats_pkg.sv
// Shared types and constants for the range AND threshold search block.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package rats_pkg;

  // Array capacity and the widths that follow from it.
  localparam int MAX_LEN = 1024;
  localparam int IDX_W   = 11;                 // one-based positions 0..MAX_LEN
  localparam int CNT_W   = 11;                 // one prefix count, 0..MAX_LEN
  localparam int ADDR_W  = $clog2(MAX_LEN);    // memory rows 1..MAX_LEN at row-1
  localparam int WORD_W  = 32;                 // element and threshold width

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  // Item kinds.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Input item.
  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] element_value;
    logic [IDX_W-1:0]  start_index;
    logic [WORD_W-1:0] threshold;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] end_index;
    logic             overflow;
  } out_item_t;

  // Access request to the prefix count memory.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } mem_req_t;

endpackage

// File: hdl/rats_mem.sv
// Prefix count memory: one write port, one read port with registered data.
// Depends on rats_pkg for the depth and the request struct.
module rats_mem #(
  parameter int DATA_W = 352
) (
  input  logic                    clk,
  input  rats_pkg::mem_req_t      req,
  input  logic [DATA_W-1:0]       wr_data,
  output logic [DATA_W-1:0]       rd_data
);

  logic [DATA_W-1:0] mem_r [rats_pkg::MAX_LEN];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/rats_and_eval.sv
// Range AND evaluation: rebuilds the AND of a range from two prefix count rows
// and compares it with the threshold as unsigned. Depends on rats_pkg.
module rats_and_eval #(
  parameter int VALUE_BITS = 32
) (
  input  logic [VALUE_BITS*rats_pkg::CNT_W-1:0] base_row,
  input  logic [VALUE_BITS*rats_pkg::CNT_W-1:0] probe_row,
  input  logic [rats_pkg::CNT_W-1:0]            range_len,
  input  logic [rats_pkg::WORD_W-1:0]           threshold,
  output logic                                  meets
);

  localparam int CW = rats_pkg::CNT_W;

  logic [rats_pkg::WORD_W-1:0] and_val;

  // A bit survives the AND when every element in the range has it set.
  always_comb begin
    and_val = '0;
    for (int b = 0; b < VALUE_BITS; b++) begin
      and_val[b] = ((probe_row[b*CW +: CW] - base_row[b*CW +: CW]) == range_len);
    end
  end

  assign meets = (and_val >= threshold);

endmodule

// File: hdl/range_and_threshold_search.sv
// Top level of the range AND threshold search block.
// Depends on rats_pkg, rats_mem and rats_and_eval.
//
// The block holds up to 1024 values as rows of per-bit prefix counts in one
// synchronous memory (row zero is implied as all zeros and is not stored).
// An append reads the last row and writes the next one, so the block is busy
// in its write state after the transfer. It gives no result unless the array is
// full; then the value is dropped and a result with overflow set is returned.
// A clear gives no result. A query reads the row before its start once, then
// runs a binary search in which every probe is a memory read followed by a
// compare, issued on the single read port of the count memory. One item is
// worked on at a time. A finished result sits in an output register and the
// next item is taken while it waits; if that item also has a result, the block
// holds in its result state until the register is free. There is no clearing
// pass after reset.
module range_and_threshold_search #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rats_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rats_pkg::out_item_t out_data
);

  localparam int CNT_W  = rats_pkg::CNT_W;
  localparam int IDX_W  = rats_pkg::IDX_W;
  localparam int ADDR_W = rats_pkg::ADDR_W;
  localparam int ROW_W  = VALUE_BITS * CNT_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_APP_WR  = 6'b000010,
    S_Q_BASE  = 6'b000100,
    S_Q_ISSUE = 6'b001000,
    S_Q_CMP   = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            lo_r, lo_nxt;
  logic [IDX_W-1:0]            hi_r, hi_nxt;
  logic [IDX_W-1:0]            mid_r, mid_nxt;
  logic [IDX_W-1:0]            best_r, best_nxt;
  logic [IDX_W-1:0]            start_r, start_nxt;
  logic [rats_pkg::WORD_W-1:0] thr_r, thr_nxt;
  logic [VALUE_BITS-1:0]       value_r, value_nxt;
  logic [ROW_W-1:0]            base_r, base_nxt;
  logic                        zero_rd_r, zero_rd_nxt;
  rats_pkg::out_item_t         res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rats_pkg::out_item_t         out_data_r, out_data_nxt;

  rats_pkg::mem_req_t          mem_req;
  logic [ROW_W-1:0]            mem_rd_data;
  logic [ROW_W-1:0]            rd_row;
  logic [ROW_W-1:0]            sum_row;
  logic [CNT_W-1:0]            range_len;
  logic                        meets;
  logic                        in_xfer;

  // Prefix count storage.
  rats_mem #(
    .DATA_W (ROW_W)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (sum_row),
    .rd_data (mem_rd_data)
  );

  // A read of row zero never reaches the memory; it reads as all zeros.
  assign rd_row = zero_rd_r ? '0 : mem_rd_data;

  // Next prefix row for an append.
  always_comb begin
    for (int b = 0; b < VALUE_BITS; b++) begin
      sum_row[b*CNT_W +: CNT_W] = rd_row[b*CNT_W +: CNT_W] + CNT_W'(value_r[b]);
    end
  end

  // Probe evaluation against the row before the start.
  assign range_len = CNT_W'(mid_r - start_r + IDX_W'(1));

  rats_and_eval #(
    .VALUE_BITS (VALUE_BITS)
  ) u_eval (
    .base_row  (base_r),
    .probe_row (rd_row),
    .range_len (range_len),
    .threshold (thr_r),
    .meets     (meets)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    best_nxt      = best_r;
    start_nxt     = start_r;
    thr_nxt       = thr_r;
    value_nxt     = value_r;
    base_nxt      = base_r;
    zero_rd_nxt   = zero_rd_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mem_req       = '0;

    // The waiting result leaves on a transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_data.kind)
            rats_pkg::KIND_APPEND: begin
              if (count_r == rats_pkg::MAX_CNT) begin
                res_nxt   = '{found: 1'b0, end_index: '0, overflow: 1'b1};
                state_nxt = S_RESP;
              end else begin
                value_nxt       = in_data.element_value[VALUE_BITS-1:0];
                zero_rd_nxt     = (count_r == '0);
                mem_req.rd_en   = (count_r != '0);
                mem_req.rd_addr = ADDR_W'(count_r - CNT_W'(1));
                state_nxt       = S_APP_WR;
              end
            end
            rats_pkg::KIND_QUERY: begin
              if (in_data.start_index == '0 ||
                  CNT_W'(in_data.start_index) > count_r) begin
                res_nxt   = '{found: 1'b0, end_index: '0, overflow: 1'b0};
                state_nxt = S_RESP;
              end else begin
                start_nxt       = in_data.start_index;
                thr_nxt         = in_data.threshold;
                lo_nxt          = in_data.start_index;
                hi_nxt          = IDX_W'(count_r);
                best_nxt        = '0;
                zero_rd_nxt     = (in_data.start_index == IDX_W'(1));
                mem_req.rd_en   = (in_data.start_index != IDX_W'(1));
                mem_req.rd_addr = ADDR_W'(in_data.start_index - IDX_W'(2));
                state_nxt       = S_Q_BASE;
              end
            end
            rats_pkg::KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Write the new row at position count + 1.
      S_APP_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ADDR_W'(count_r);
        count_nxt       = count_r + CNT_W'(1);
        state_nxt       = S_IDLE;
      end

      // Keep the row before the start for all probes.
      S_Q_BASE: begin
        base_nxt  = rd_row;
        state_nxt = S_Q_ISSUE;
      end

      // Pick the next midpoint or finish the search.
      S_Q_ISSUE: begin
        if (lo_r <= hi_r) begin
          mid_nxt         = lo_r + ((hi_r - lo_r) >> 1);
          zero_rd_nxt     = 1'b0;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(mid_nxt - IDX_W'(1));
          state_nxt       = S_Q_CMP;
        end else begin
          res_nxt   = '{found: (best_r != '0), end_index: best_r, overflow: 1'b0};
          state_nxt = S_RESP;
        end
      end

      // Narrow the search window on the probe outcome.
      S_Q_CMP: begin
        if (meets) begin
          best_nxt = mid_r;
          lo_nxt   = mid_r + IDX_W'(1);
        end else begin
          hi_nxt   = mid_r - IDX_W'(1);
        end
        state_nxt = S_Q_ISSUE;
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    best_r     <= best_nxt;
    start_r    <= start_nxt;
    thr_r      <= thr_nxt;
    value_r    <= value_nxt;
    base_r     <= base_nxt;
    zero_rd_r  <= zero_rd_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/rats_checker.sv
// Port-level checks for range_and_threshold_search, attached with bind.
// Depends on rats_pkg and the top level's port list.
module rats_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rats_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rats_pkg::out_item_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A result that is not found carries end index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.end_index == '0)
    else $error("not-found result with nonzero end index");

  // A found result names a real position.
  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.end_index != '0)
    else $error("found result with end index zero");

  // An overflow result never reports a hit.
  a_ovf_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> !out_data.found)
    else $error("overflow result marked found");

  // Appends and queries leave the block busy after their transfer.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.kind == rats_pkg::KIND_APPEND || in_data.kind == rats_pkg::KIND_QUERY)
    |=> in_stall)
    else $error("append or query transfer not followed by a busy cycle");

endmodule

bind range_and_threshold_search rats_checker u_rats_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_top.sv
// Self-checking testbench for range_and_threshold_search: appends, clears and
// threshold queries against a behavioral search predictor, random idling both sides.
// Depends on rats_pkg and the RTL in hdl/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = rats_pkg::MAX_LEN;
  localparam int IDX_W   = rats_pkg::IDX_W;
  localparam int WORD_W  = rats_pkg::WORD_W;

  // Kind code that the block must ignore.
  localparam logic [1:0] KIND_IGNORED = 2'd3;
  // Quiet cycles allowed before the run is declared hung.
  localparam int HANG_LIMIT   = 2000;
  // Cycles to wait after the last result, beyond the longest query.
  localparam int DRAIN_CYCLES = 60;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  rats_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rats_pkg::out_item_t out_data;

  // Predictor state: the stored array and the results still owed.
  logic [WORD_W-1:0]   stored_values [1:MAX_LEN];
  int unsigned         stored_count = 0;
  rats_pkg::out_item_t pending_results [$];
  int                  error_count = 0;
  bit                  send_calm = 1'b0;
  bit                  recv_calm = 1'b0;

  range_and_threshold_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock generation.
  initial begin
    forever #2 clk = ~clk;
  end

  // Update the array and work out the result that an accepted item owes.
  // The search walks the range AND forward; it only loses bits as the range
  // grows, so the last end that still meets the threshold is the answer.
  function automatic void update_search_model(input rats_pkg::in_item_t item);
    rats_pkg::out_item_t result;
    logic [WORD_W-1:0]   run_and;
    int unsigned         pos;
    result = '0;
    case (item.kind)
      rats_pkg::KIND_APPEND: begin
        if (stored_count >= MAX_LEN) begin
          result.overflow = 1'b1;
          pending_results = {pending_results, result};
        end else begin
          stored_count++;
          stored_values[stored_count] = item.element_value;
        end
      end
      rats_pkg::KIND_QUERY: begin
        if (item.start_index != 0 && item.start_index <= stored_count) begin
          run_and = '1;
          for (pos = item.start_index; pos <= stored_count; pos++) begin
            run_and &= stored_values[pos];
            if (run_and < item.threshold) break;
            result.found     = 1'b1;
            result.end_index = IDX_W'(pos);
          end
        end
        pending_results = {pending_results, result};
      end
      rats_pkg::KIND_CLEAR: begin
        stored_count = 0;
      end
      default: begin
      end
    endcase
  endfunction

  // Present one item after a random gap and wait for its transfer.
  task automatic send_item(input logic [1:0] kind, input logic [WORD_W-1:0] value,
                           input logic [IDX_W-1:0] first_pos,
                           input logic [WORD_W-1:0] bound);
    rats_pkg::in_item_t item;
    int                 gap;
    item.kind          = kind;
    item.element_value = value;
    item.start_index   = first_pos;
    item.threshold     = bound;
    if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    update_search_model(item);
  endtask

  // Start position for a query: mostly inside the array, sometimes at or past its edges.
  function automatic logic [IDX_W-1:0] pick_start();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return IDX_W'(stored_count + 1);
      2: return IDX_W'($urandom);
      3: return IDX_W'(stored_count);
      default: return (stored_count == 0) ? IDX_W'(1) : IDX_W'($urandom_range(1, stored_count));
    endcase
  endfunction

  // Threshold for a query: corner values, or the AND of a real range and its neighbors,
  // so that the search boundary lands inside the array.
  function automatic logic [WORD_W-1:0] pick_threshold(input int unsigned first_pos);
    logic [WORD_W-1:0] range_and;
    int unsigned       last_pos, pos;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return {1'b1, 31'($urandom)};
      default: begin
        if (first_pos == 0 || first_pos > stored_count) return $urandom;
        last_pos  = $urandom_range(first_pos, stored_count);
        range_and = '1;
        for (pos = first_pos; pos <= last_pos; pos++) range_and &= stored_values[pos];
        case ($urandom_range(0, 2))
          0: return range_and;
          1: return range_and + 1;
          default: return range_and - 1;
        endcase
      end
    endcase
  endfunction

  // Element value: mostly a shared base with random extra bits, so ANDs survive long ranges.
  function automatic logic [WORD_W-1:0] next_value(input logic [WORD_W-1:0] base);
    case ($urandom_range(0, 39))
      0: return $urandom;
      1: return '1;
      2: return '0;
      default: return base | ($urandom & $urandom);
    endcase
  endfunction

  task automatic send_query(input logic [IDX_W-1:0] first_pos,
                            input logic [WORD_W-1:0] bound);
    send_item(rats_pkg::KIND_QUERY, $urandom, first_pos, bound);
  endtask

  task automatic send_append(input logic [WORD_W-1:0] value);
    send_item(rats_pkg::KIND_APPEND, value, IDX_W'($urandom), $urandom);
  endtask

  task automatic send_clear();
    send_item(rats_pkg::KIND_CLEAR, $urandom, IDX_W'($urandom), $urandom);
  endtask

  // Queries on an empty array, a zero start, and an ignored kind.
  task automatic test_empty_array();
    send_query(IDX_W'(1), '0);
    send_query('0, '0);
    send_item(KIND_IGNORED, '1, '1, '1);
    send_query('1, '1);
  endtask

  // A short array where the answer moves with the threshold, including bit 31.
  task automatic test_search_basics();
    send_append(32'hFFFF_FFFF);
    send_append(32'h8000_0001);
    send_item(KIND_IGNORED, '0, '0, '0);
    send_append(32'h8000_0000);
    send_append(32'h0000_0000);
    send_query(IDX_W'(1), 32'h0000_0000);
    send_query(IDX_W'(1), 32'h8000_0000);
    send_query(IDX_W'(1), 32'hFFFF_FFFF);
    send_query(IDX_W'(2), 32'h8000_0001);
    send_query(IDX_W'(4), 32'h0000_0001);
    send_query(IDX_W'(5), 32'h0000_0000);
    send_query('0, 32'h0000_0000);
    send_query('1, 32'h0000_0000);
  endtask

  // A clear empties the array and the next set starts from row one.
  task automatic test_clear_and_reuse();
    send_clear();
    send_query(IDX_W'(1), '0);
    send_append(32'h5A5A_5A5A);
    send_query(IDX_W'(1), 32'h5A5A_5A5A);
    send_query(IDX_W'(1), 32'h5A5A_5A5B);
    send_clear();
  endtask

  // Many small sets of random appends and queries, with some noise items mixed in.
  task automatic test_random_sets(input int unsigned item_goal);
    int unsigned       sent, set_len, i;
    logic [IDX_W-1:0]  first_pos;
    logic [WORD_W-1:0] base;
    sent = 0;
    while (sent < item_goal) begin
      // Now and then the next set keeps growing the old array.
      if ($urandom_range(0, 4) != 0) begin
        send_clear();
        sent++;
      end
      set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      base    = ~($urandom & $urandom & $urandom);
      for (i = 0; i < set_len; i++) begin
        case ($urandom_range(0, 19))
          0: send_item(KIND_IGNORED, $urandom, IDX_W'($urandom), $urandom);
          1, 2, 3, 4, 5, 6: begin
            first_pos = pick_start();
            send_query(first_pos, pick_threshold(first_pos));
            sent++;
          end
          default: begin
            send_append(next_value(base));
            sent++;
          end
        endcase
      end
    end
  endtask

  // Fill the array to capacity with queries along the way, then overflow it.
  task automatic test_full_array();
    logic [IDX_W-1:0]  first_pos;
    logic [WORD_W-1:0] base;
    base = '1;
    send_clear();
    while (stored_count < MAX_LEN) begin
      // Values share a base in segments, so ANDs reach across long ranges.
      if (stored_count % 96 == 0) base = ~($urandom & $urandom & $urandom);
      if ($urandom_range(0, 24) == 0) begin
        first_pos = pick_start();
        send_query(first_pos, pick_threshold(first_pos));
      end else begin
        send_append(next_value(base));
      end
    end
    send_query(IDX_W'(1), '0);
    send_query(IDX_W'(MAX_LEN), '0);
    send_query(IDX_W'(MAX_LEN + 1), '0);
    repeat (4) send_append($urandom);
    repeat (16) begin
      first_pos = pick_start();
      send_query(first_pos, pick_threshold(first_pos));
    end
    send_append('1);
    send_clear();
    send_query(IDX_W'(1), '0);
  endtask

  // Result side: random stalls after each transfer, each result checked against the oldest
  // expectation.
  initial begin : result_checker
    int                  stall_left;
    rats_pkg::out_item_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: found %0d end_index %0d overflow %0d",
                 out_data.found, out_data.end_index, out_data.overflow);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            error_count++;
          end
          if (out_data.end_index !== want.end_index) begin
            $error("end_index: expected %0d, got %0d", want.end_index, out_data.end_index);
            error_count++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
            error_count++;
          end
        end
        if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
        stall_left = recv_calm ? 0 : $urandom_range(0, 5);
        if (stall_left > 0) out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end
    end
  end

  // Hang detection: too many cycles without any transfer on either side.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall == 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // Test sequence.
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_array();
    test_search_basics();
    test_clear_and_reuse();
    test_random_sets(130);
    test_full_array();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
